@@ hw/rtl/url_percent_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// url_percent_decoder assertion macros
// Concurrent assertion forms for the percent decoder result queue.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define UPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define UPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/upd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helpers for the form-urlencoded decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_type;

   // results produced by one item, in output order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_PERCENT = 3'b010,
      PH_DIGIT   = 3'b100
   } phase_type;

   // non-hex characters give a zero nibble
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
         n = c[3:0];
      else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
         n = 4'(c - CH_UPPER_A + HEX_TEN);
      else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
         n = 4'(c - CH_LOWER_A + HEX_TEN);
      return n;
   endfunction

   function automatic logic [7:0] plain_of(input logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

endpackage

@@ hw/rtl/upd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_decode
// Escape tracker and per-byte decode; emits zero, one or two results.
// ----------------------------------------------------------------------------
module upd_decode (
   input  logic             clock,
   input  logic             reset,
   input  upd_pkg::req_type item,
   input  logic             fire,
   output upd_pkg::push_type push
);
   import upd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      push        = '0;
      unique case (phase_ff)
         PH_PERCENT: begin
            if (item.in_last) begin
               // percent too close to the end: pass it through literally
               push.count  = 2'd2;
               push.first  = '{out_byte: CH_PERCENT, run_end: 1'b0, string_end: 1'b0};
               push.second = '{out_byte: plain_of(item.in_byte), run_end: 1'b1,
                               string_end: 1'b1};
               phase_in    = PH_IDLE;
            end else begin
               held_in  = item.in_byte;
               phase_in = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            push.count = 2'd1;
            push.first = '{out_byte: {nibble_of(held_ff), nibble_of(item.in_byte)},
                           run_end: 1'b1, string_end: item.in_last};
            phase_in   = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
            if (item.in_byte == CH_PERCENT && !item.in_last) begin
               phase_in = PH_PERCENT;
            end else begin
               push.count = 2'd1;
               push.first = '{out_byte: plain_of(item.in_byte), run_end: 1'b1,
                              string_end: item.in_last};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule

@@ hw/rtl/upd_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_out_queue
// Two-entry result queue; takes up to two results and sends one per cycle unless rsp_stall holds it.
// ----------------------------------------------------------------------------
`include "url_percent_decoder_macros.svh"

module upd_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  upd_pkg::push_type push,
   input  logic              push_en,
   output logic [1:0]        free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output upd_pkg::rsp_type  rsp_data
);
   import upd_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   rsp_type    q0_ff, q0_in;
   rsp_type    q1_ff, q1_in;
   logic       pop;
   logic [1:0] push_n;
   logic [1:0] kept;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign free      = 2'd2 - cnt_ff + {1'b0, pop};
   assign push_n    = push_en ? push.count : 2'd0;
   assign kept      = cnt_ff - {1'b0, pop};

   always_comb begin
      cnt_in = kept + push_n;
      case (kept)
         2'd0: begin
            q0_in = push.first;
            q1_in = push.second;
         end
         2'd1: begin
            q0_in = pop ? q1_ff : q0_ff;
            q1_in = push.first;
         end
         default: begin
            q0_in = q0_ff;
            q1_in = q1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   `UPD_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff != 2'd3,
      "result queue count out of range")
   `UPD_ASSERT_NOW(a_no_overflow, clock, reset, push_en, push.count <= free,
      "results pushed without room")
   `UPD_ASSERT_NOW(a_pair_order, clock, reset, push_en && push.count == 2'd2,
      !push.first.run_end && push.second.run_end, "run_end misplaced in result pair")
   `UPD_ASSERT_NEXT(a_pair_follows, clock, reset,
      pop && !rsp_data.run_end && cnt_ff == 2'd1 && !push_en, 1'b0,
      "first of a pair left without its second")

endmodule

@@ hw/rtl/url_percent_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming form-urlencoded decoder: plus to space, percent escapes to bytes.
// ----------------------------------------------------------------------------
// Takes one encoded byte per cycle unless req_stall holds it off and returns
// decoded bytes via an input register, then a two-entry result queue. A percent sign
// and the first hex digit give no result; a percent sign directly before the
// string's last byte gives two. The percent itself leaves a free slot in the
// queue, so while the result side keeps up the extra result costs no input
// cycle; the input is held off only when the queue lacks room for the results
// of the waiting byte, which happens only under result stalls. run_end marks
// the last result of each input byte and string_end the final decoded byte of
// the string.
module url_percent_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  upd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output upd_pkg::rsp_type rsp_data
);
   import upd_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   req_type  s1_item_ff;
   push_type push;
   logic [1:0] free;
   logic     advance;
   logic     take;

   assign advance   = s1_valid_ff && (push.count <= free);
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff <= req_data;
      end
   end

   upd_decode u_decode (
      .clock (clock),
      .reset (reset),
      .item  (s1_item_ff),
      .fire  (advance),
      .push  (push)
   );

   upd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_en   (advance),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/upd_decode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_decode_checker
// Watches both channels of the percent decoder, predicts the decoded bytes
// of every input transfer and compares each result transfer in order.
// ----------------------------------------------------------------------------
module upd_decode_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  upd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  upd_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               checked_count
);
   import upd_pkg::*;

   rsp_type    decoded_q[$];
   phase_type  esc_phase = PH_IDLE;
   logic [7:0] first_digit = '0;
   int         errors = 0;
   int         checked = 0;

   // offsets wrap for bytes below the range start, so one compare per range
   function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] d;
      d = ch - CH_ZERO;
      if (d < HEX_TEN)
         return d[3:0];
      d = ch - CH_UPPER_A;
      if (d < 8'd6)
         return 4'(d + HEX_TEN);
      d = ch - CH_LOWER_A;
      if (d < 8'd6)
         return 4'(d + HEX_TEN);
      return 4'd0;
   endfunction

   task automatic expect_rsp(input rsp_type r);
      decoded_q = {decoded_q, r};
   endtask

   task automatic decode_byte(input req_type item);
      logic [7:0] ch;
      ch = (item.in_byte == CH_PLUS) ? CH_SPACE : item.in_byte;
      case (esc_phase)
         PH_PERCENT: begin
            if (item.in_last) begin
               // too short for an escape: literal percent, then the byte itself
               expect_rsp(rsp_type'{out_byte: CH_PERCENT, run_end: 1'b0,
                                    string_end: 1'b0});
               expect_rsp(rsp_type'{out_byte: ch, run_end: 1'b1,
                                    string_end: 1'b1});
               esc_phase = PH_IDLE;
            end else begin
               first_digit = item.in_byte;
               esc_phase   = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            expect_rsp(rsp_type'{
               out_byte:   {hex_nibble(first_digit), hex_nibble(item.in_byte)},
               run_end:    1'b1,
               string_end: item.in_last});
            esc_phase = PH_IDLE;
         end
         default: begin
            if (item.in_byte == CH_PERCENT && !item.in_last)
               esc_phase = PH_PERCENT;
            else
               expect_rsp(rsp_type'{out_byte: ch, run_end: 1'b1,
                                    string_end: item.in_last});
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         esc_phase   = PH_IDLE;
         first_digit = '0;
         decoded_q.delete();
      end else begin
         if (req_valid && !req_stall)
            decode_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual byte=%h run=%b str=%b",
                        $time, rsp_data.out_byte, rsp_data.run_end, rsp_data.string_end);
            end else begin
               want = decoded_q.pop_front();
               checked++;
               if (rsp_data.out_byte !== want.out_byte || rsp_data.run_end !== want.run_end
                   || rsp_data.string_end !== want.string_end) begin
                  errors++;
                  $display("%0t: mismatch: expected byte=%h run=%b str=%b, ",
                           $time, want.out_byte, want.run_end, want.string_end,
                           "actual byte=%h run=%b str=%b",
                           rsp_data.out_byte, rsp_data.run_end, rsp_data.string_end);
               end
            end
         end
      end
      pending_count <= decoded_q.size();
      fail_count    <= errors;
      checked_count <= checked;
   end

endmodule

@@ tb/sv/tb_url_percent_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_decoder
// Drives encoded strings into the decoder: a directed set of escapes, plus
// signs and short trailing percents, then random strings under three idle
// patterns. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder;
   import upd_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int send_idle_pct  = 24;
   int recv_stall_pct = 69;
   int items_sent     = 0;
   int strings_sent   = 0;
   int percents_sent  = 0;
   int cycle_count    = 0;
   int fail_count;
   int pending_count;
   int checked_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   url_percent_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   upd_decode_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] ch, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{in_byte: ch, in_last: last};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      if (ch == CH_PERCENT)
         percents_sent++;
      if (last)
         strings_sent++;
   endtask

   // mostly hex digits of either case, sometimes any byte
   function automatic logic [7:0] hex_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return CH_ZERO + 8'($urandom_range(0, 9));
         3, 4:    return CH_UPPER_A + 8'($urandom_range(0, 5));
         5, 6:    return CH_LOWER_A + 8'($urandom_range(0, 5));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_string();
      logic [7:0] text[$];
      int         len;
      int         pick;
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 99) < 15) begin
         // noise: percents, plus signs, hex digits and any bytes in any order
         repeat (len) begin
            case ($urandom_range(0, 3))
               0:       text = {text, CH_PERCENT};
               1:       text = {text, CH_PLUS};
               2:       text = {text, hex_char()};
               default: text = {text, 8'($urandom_range(0, 255))};
            endcase
         end
      end else begin
         while (text.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               text = {text, 8'($urandom_range(0, 255))};
            else if (pick < 50)
               text = {text, CH_PLUS};
            else if (pick < 85)
               text = {text, CH_PERCENT, hex_char(), hex_char()};
            else
               text = {text, CH_PERCENT};
         end
      end
      foreach (text[i])
         send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin
      int random_start;
      int done;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(CH_PLUS, 1'b1);
      // upper-case escape, then a plain last byte
      send_byte(CH_PERCENT, 1'b0);
      send_byte("4", 1'b0);
      send_byte("1", 1'b0);
      send_byte("b", 1'b1);
      send_byte(CH_PERCENT, 1'b0);
      send_byte("f", 1'b0);
      send_byte("f", 1'b0);
      // non-hex digit gives a zero nibble; escape closes the string
      send_byte(CH_PERCENT, 1'b0);
      send_byte("G", 1'b0);
      send_byte("0", 1'b1);
      send_byte(CH_PERCENT, 1'b1);
      // percent right before the last byte: literal percent, plus to space
      send_byte(CH_PERCENT, 1'b0);
      send_byte(CH_PLUS, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(CH_PERCENT, 1'b0);
      send_byte(CH_PERCENT, 1'b0);
      send_byte(CH_PERCENT, 1'b0);
      send_byte("x", 1'b1);
      send_byte(CH_PERCENT, 1'b0);
      send_byte("a", 1'b0);
      send_byte("F", 1'b1);

      random_start = items_sent;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         if (done >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else if (done >= RANDOM_ITEMS / 3) begin
            send_idle_pct  = 69;
            recv_stall_pct = 24;
         end
         send_random_string();
         done = items_sent - random_start;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d strings, %0d of them percent signs",
               items_sent, strings_sent, percents_sent);
      $display("checked %0d decoded bytes under three idle patterns", checked_count);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
